>>> src/lpmr_pkg.sv
`timescale 1ns / 1ps

package lpmr_pkg;

	localparam int RING_DEPTH  = 1024;
	localparam int AW          = $clog2(RING_DEPTH);
	localparam int SW          = AW + 1;
	localparam int MAX_PAYLOAD = 64;
	localparam int LW          = 7;
	localparam int DW          = 8;
	localparam int HDR_BYTES   = 4;
	localparam int MIN_SIZE    = 8;

	typedef enum logic [1:0] {
		FUNC_WRITE  = 2'd0,
		FUNC_READ   = 2'd1,
		FUNC_PEEK   = 2'd2,
		FUNC_STATUS = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		STAT_OK       = 3'd0,
		STAT_NO_ROOM  = 3'd1,
		STAT_EMPTY    = 3'd2,
		STAT_CORRUPT  = 3'd3,
		STAT_MISMATCH = 3'd4
	} status_t;

	localparam logic REG_RING_SIZE = 1'b0;
	localparam logic REG_MAX_LEN   = 1'b1;

	typedef enum logic [3:0] {
		S_IDLE,
		S_EXEC,
		S_WR_HDR,
		S_WR_BODY,
		S_RD_HA,
		S_RD_HD,
		S_RD_CHK,
		S_BY_A,
		S_BY_D,
		S_EMIT
	} state_t;

	typedef struct packed {
		logic [DW-1:0] data;
		logic          last;
		status_t       status;
		logic [LW-1:0] len;
		logic [AW-1:0] used;
		logic [AW-1:0] free_pl;
		logic          can_read;
	} res_t;

	typedef struct packed {
		logic          we;
		logic [AW-1:0] waddr;
		logic [DW-1:0] wdata;
		logic          re;
		logic [AW-1:0] raddr;
	} mem_req_t;

	function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] p,
			input logic [SW-1:0] s);
		logic [SW-1:0] n;
		begin
			n = {1'b0, p} + SW'(1);
			ring_inc = (n == s) ? '0 : n[AW-1:0];
		end
	endfunction

	function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] p,
			input logic [LW-1:0] l, input logic [SW-1:0] s);
		logic [SW-1:0] n;
		begin
			n = {1'b0, p} + SW'(l);
			ring_add = (n >= s) ? AW'(n - s) : n[AW-1:0];
		end
	endfunction

endpackage

>>> src/length_prefixed_message_ring_core.sv
// A write byte is answered after its body write; the first byte of a message first writes
// four header bytes through the single memory write port. A status query, an empty read
// or a rejected first byte is answered straight from the execute state.
// A read or peek fetches the four header bytes (address, then data), checks the length,
// then fetches and captures each byte in turn; a corrupt or empty message ends at the check.
// One item in flight. Reset clears pointers, registers and the open message; ring undefined.
`timescale 1ns / 1ps

module length_prefixed_message_ring_core import lpmr_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  logic [1:0]    func,
	input  logic [LW-1:0] msg_len,
	input  logic [DW-1:0] data_in,
	input  logic          data_last,
	output logic          out_valid,
	input  logic          out_stall,
	output logic [DW-1:0] data_out,
	output logic          out_last,
	output logic [2:0]    status,
	output logic [LW-1:0] msg_len_out,
	output logic [AW-1:0] used_bytes,
	output logic [AW-1:0] free_payload,
	output logic          can_read,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic          cfg_index,
	input  logic [SW-1:0] cfg_data
);

	res_t          res, out_q;
	logic          out_valid_q;
	logic          out_free, emit;
	mem_req_t      mreq;
	logic [DW-1:0] mrdata;

	assign out_free = !out_valid_q || !out_stall;

	lpmr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.func      (func),
		.msg_len   (msg_len),
		.data_in   (data_in),
		.data_last (data_last),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_free  (out_free),
		.emit      (emit),
		.res       (res),
		.mreq      (mreq),
		.mrdata    (mrdata)
	);

	lpmr_ram u_ram (
		.clk   (clk),
		.req   (mreq),
		.rdata (mrdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign data_out     = out_q.data;
	assign out_last     = out_q.last;
	assign status       = out_q.status;
	assign msg_len_out  = out_q.len;
	assign used_bytes   = out_q.used;
	assign free_payload = out_q.free_pl;
	assign can_read     = out_q.can_read;

endmodule

>>> src/lpmr_ram.sv
`timescale 1ns / 1ps

module lpmr_ram import lpmr_pkg::*; (
	input  logic          clk,
	input  mem_req_t      req,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [RING_DEPTH];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
	end

	// hold read data until the next read
	always_ff @(posedge clk) begin
		if (req.re) begin
			rdata <= mem[req.raddr];
		end
	end

endmodule

>>> src/lpmr_ctrl.sv
`timescale 1ns / 1ps

module lpmr_ctrl import lpmr_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  logic [1:0]    func,
	input  logic [LW-1:0] msg_len,
	input  logic [DW-1:0] data_in,
	input  logic          data_last,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic          cfg_index,
	input  logic [SW-1:0] cfg_data,
	input  logic          out_free,
	output logic          emit,
	output res_t          res,
	output mem_req_t      mreq,
	input  logic [DW-1:0] mrdata
);

	state_t        state_q, state_d;
	logic [AW-1:0] rp_q, rp_d, wp_q, wp_d, wcur_q, wcur_d, rcur_q, rcur_d;
	logic          wact_q, wact_d, wrej_q, wrej_d;
	logic [LW-1:0] bw_q, bw_d, exp_q, exp_d;
	logic [SW-1:0] size_q;
	logic [LW-1:0] max_q;
	func_t         func_q, func_d;
	logic [LW-1:0] len_in_q, len_in_d;
	logic [DW-1:0] din_q, din_d;
	logic          last_q, last_d;
	logic [1:0]    cnt_q, cnt_d;
	logic          hnz_q, hnz_d;
	logic [DW-1:0] rlen_q, rlen_d;
	logic [LW-1:0] idx_q, idx_d;
	status_t       st_q, st_d;
	logic [DW-1:0] pdata_q, pdata_d;
	logic          plast_q, plast_d;
	logic [LW-1:0] plen_q, plen_d;
	logic          more_q, more_d;

	logic [SW-1:0] used, free_sp;
	logic          cfg_fire, in_fire;
	logic          wrote;
	logic [AW-1:0] cur_n;
	logic [LW-1:0] bw_n, need;

	assign in_stall  = (state_q != S_IDLE);
	assign cfg_ready = (state_q == S_IDLE);
	assign in_fire   = in_valid && !in_stall;
	assign cfg_fire  = cfg_valid && cfg_ready;

	assign used    = (wp_q >= rp_q) ? SW'(wp_q - rp_q)
		: SW'(size_q - {1'b0, rp_q} + {1'b0, wp_q});
	assign free_sp = size_q - SW'(1) - used;

	always_comb begin
		res.data     = pdata_q;
		res.last     = plast_q;
		res.status   = st_q;
		res.len      = plen_q;
		res.used     = used[AW-1:0];
		res.free_pl  = (free_sp > SW'(HDR_BYTES)) ? AW'(free_sp - SW'(HDR_BYTES)) : '0;
		res.can_read = (used != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		rp_d     = rp_q;
		wp_d     = wp_q;
		wcur_d   = wcur_q;
		rcur_d   = rcur_q;
		wact_d   = wact_q;
		wrej_d   = wrej_q;
		bw_d     = bw_q;
		exp_d    = exp_q;
		func_d   = func_q;
		len_in_d = len_in_q;
		din_d    = din_q;
		last_d   = last_q;
		cnt_d    = cnt_q;
		hnz_d    = hnz_q;
		rlen_d   = rlen_q;
		idx_d    = idx_q;
		st_d     = st_q;
		pdata_d  = pdata_q;
		plast_d  = plast_q;
		plen_d   = plen_q;
		more_d   = more_q;
		emit     = 1'b0;
		mreq     = '0;
		wrote    = bw_q < exp_q;
		cur_n    = wrote ? ring_inc(wcur_q, size_q) : wcur_q;
		bw_n     = (bw_q <= exp_q) ? bw_q + LW'(1) : bw_q;
		need     = (exp_q == '0) ? LW'(1) : exp_q;

		case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					func_d   = func_t'(func);
					len_in_d = msg_len;
					din_d    = data_in;
					last_d   = data_last;
					state_d  = S_EXEC;
				end
			end
			S_EXEC: begin
				pdata_d = '0;
				plast_d = 1'b1;
				plen_d  = '0;
				more_d  = 1'b0;
				st_d    = STAT_OK;
				case (func_q)
					FUNC_WRITE: begin
						if (!wact_q && !wrej_q) begin
							if (len_in_q > max_q ||
									free_sp < SW'(len_in_q) + SW'(HDR_BYTES)) begin
								wrej_d  = !last_q;
								st_d    = STAT_NO_ROOM;
								state_d = S_EMIT;
							end else begin
								wcur_d  = wp_q;
								exp_d   = len_in_q;
								bw_d    = '0;
								wact_d  = 1'b1;
								cnt_d   = '0;
								state_d = S_WR_HDR;
							end
						end else begin
							state_d = S_WR_BODY;
						end
					end
					FUNC_STATUS: begin
						state_d = S_EMIT;
					end
					default: begin
						if (rp_q == wp_q) begin
							st_d    = STAT_EMPTY;
							state_d = S_EMIT;
						end else begin
							rcur_d  = rp_q;
							cnt_d   = '0;
							hnz_d   = 1'b0;
							state_d = S_RD_HA;
						end
					end
				endcase
			end
			S_WR_HDR: begin
				// big-endian length: three zero bytes, then the length byte
				mreq.we    = 1'b1;
				mreq.waddr = wcur_q;
				mreq.wdata = (cnt_q == 2'd3) ? DW'(exp_q) : '0;
				wcur_d     = ring_inc(wcur_q, size_q);
				cnt_d      = cnt_q + 2'd1;
				if (cnt_q == 2'd3) begin
					state_d = S_WR_BODY;
				end
			end
			S_WR_BODY: begin
				state_d = S_EMIT;
				if (wrej_q) begin
					if (last_q) begin
						wrej_d = 1'b0;
					end
					st_d = STAT_NO_ROOM;
				end else begin
					mreq.we    = wrote;
					mreq.waddr = wcur_q;
					mreq.wdata = din_q;
					wcur_d     = cur_n;
					bw_d       = bw_n;
					if (last_q) begin
						if (bw_n == need) begin
							wp_d = cur_n;
						end else begin
							st_d = STAT_MISMATCH;
						end
						wcur_d = '0;
						wact_d = 1'b0;
						wrej_d = 1'b0;
						bw_d   = '0;
						exp_d  = '0;
					end
				end
			end
			S_RD_HA: begin
				mreq.re    = 1'b1;
				mreq.raddr = rcur_q;
				rcur_d     = ring_inc(rcur_q, size_q);
				state_d    = S_RD_HD;
			end
			S_RD_HD: begin
				if (cnt_q == 2'd3) begin
					rlen_d  = mrdata;
					state_d = S_RD_CHK;
				end else begin
					hnz_d   = hnz_q || (mrdata != '0);
					state_d = S_RD_HA;
				end
				cnt_d = cnt_q + 2'd1;
			end
			S_RD_CHK: begin
				if (hnz_q || rlen_q > DW'(max_q)) begin
					st_d    = STAT_CORRUPT;
					state_d = S_EMIT;
				end else begin
					if (func_q == FUNC_READ) begin
						rp_d = ring_add(rcur_q, rlen_q[LW-1:0], size_q);
					end
					if (rlen_q == '0) begin
						state_d = S_EMIT;
					end else begin
						idx_d   = '0;
						state_d = S_BY_A;
					end
				end
			end
			S_BY_A: begin
				mreq.re    = 1'b1;
				mreq.raddr = rcur_q;
				rcur_d     = ring_inc(rcur_q, size_q);
				state_d    = S_BY_D;
			end
			S_BY_D: begin
				pdata_d = mrdata;
				plen_d  = rlen_q[LW-1:0];
				plast_d = (idx_q + LW'(1) == rlen_q[LW-1:0]);
				more_d  = (idx_q + LW'(1) != rlen_q[LW-1:0]);
				st_d    = STAT_OK;
				idx_d   = idx_q + LW'(1);
				state_d = S_EMIT;
			end
			S_EMIT: begin
				if (out_free) begin
					emit    = 1'b1;
					state_d = more_q ? S_BY_A : S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rp_q   <= '0;
			wp_q   <= '0;
			wcur_q <= '0;
			wact_q <= 1'b0;
			wrej_q <= 1'b0;
			bw_q   <= '0;
			exp_q  <= '0;
			size_q <= SW'(RING_DEPTH);
			max_q  <= LW'(MAX_PAYLOAD);
		end else if (cfg_fire) begin
			if (cfg_index == REG_RING_SIZE) begin
				if (cfg_data < SW'(MIN_SIZE)) begin
					size_q <= SW'(MIN_SIZE);
				end else if (cfg_data > SW'(RING_DEPTH)) begin
					size_q <= SW'(RING_DEPTH);
				end else begin
					size_q <= cfg_data;
				end
				// empty the ring and drop any open message
				rp_q   <= '0;
				wp_q   <= '0;
				wcur_q <= '0;
				wact_q <= 1'b0;
				wrej_q <= 1'b0;
				bw_q   <= '0;
				exp_q  <= '0;
			end else begin
				max_q <= (cfg_data[LW-1:0] > LW'(MAX_PAYLOAD)) ? LW'(MAX_PAYLOAD)
					: cfg_data[LW-1:0];
			end
		end else begin
			rp_q   <= rp_d;
			wp_q   <= wp_d;
			wcur_q <= wcur_d;
			wact_q <= wact_d;
			wrej_q <= wrej_d;
			bw_q   <= bw_d;
			exp_q  <= exp_d;
		end
	end

	always_ff @(posedge clk) begin
		func_q   <= func_d;
		len_in_q <= len_in_d;
		din_q    <= din_d;
		last_q   <= last_d;
		rcur_q   <= rcur_d;
		cnt_q    <= cnt_d;
		hnz_q    <= hnz_d;
		rlen_q   <= rlen_d;
		idx_q    <= idx_d;
		st_q     <= st_d;
		pdata_q  <= pdata_d;
		plast_q  <= plast_d;
		plen_q   <= plen_d;
		more_q   <= more_d;
	end

endmodule

>>> sim/tb_length_prefixed_message_ring_core.sv
`timescale 1ns / 1ps

module tb_length_prefixed_message_ring_core;
	import lpmr_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int SETTLE_CYCLES  = 16;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          in_valid = 1'b0;
	logic          in_stall;
	logic [1:0]    func = FUNC_WRITE;
	logic [LW-1:0] msg_len = '0;
	logic [DW-1:0] data_in = '0;
	logic          data_last = 1'b0;
	logic          out_valid;
	logic          out_stall = 1'b0;
	logic [DW-1:0] data_out;
	logic          out_last;
	logic [2:0]    status;
	logic [LW-1:0] msg_len_out;
	logic [AW-1:0] used_bytes;
	logic [AW-1:0] free_payload;
	logic          can_read;
	logic          cfg_valid = 1'b0;
	logic          cfg_ready;
	logic          cfg_index = REG_RING_SIZE;
	logic [SW-1:0] cfg_data = '0;

	length_prefixed_message_ring_core u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.func(func), .msg_len(msg_len), .data_in(data_in), .data_last(data_last),
		.out_valid(out_valid), .out_stall(out_stall),
		.data_out(data_out), .out_last(out_last), .status(status),
		.msg_len_out(msg_len_out), .used_bytes(used_bytes),
		.free_payload(free_payload), .can_read(can_read),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// ring shadow
	logic [DW-1:0] ring_mem [0:RING_DEPTH-1];
	int unsigned   rd_p, wr_p, wr_cur, n_bytes, want_len;
	bit            wr_open, wr_drop;
	logic [SW-1:0] cfg_size = SW'(RING_DEPTH);
	logic [LW-1:0] cfg_max = LW'(MAX_PAYLOAD);

	res_t pending_results [$];
	int   errors = 0;
	int   words_sent = 0;
	int   results_checked = 0;
	int   reg_writes = 0;
	int   sender_idle_pct = 0;
	int   recv_stall_pct = 0;
	int   quiet_cycles = 0;

	function automatic int unsigned span_now();
		if (cfg_size < MIN_SIZE)
			return MIN_SIZE;
		if (cfg_size > RING_DEPTH)
			return RING_DEPTH;
		return cfg_size;
	endfunction

	function automatic int unsigned max_now();
		return (cfg_max > MAX_PAYLOAD) ? MAX_PAYLOAD : cfg_max;
	endfunction

	function automatic int unsigned used_now();
		int unsigned s, r, w;
		s = span_now();
		r = rd_p % s;
		w = wr_p % s;
		return (w >= r) ? (w - r) : (s - r + w);
	endfunction

	function automatic int unsigned free_now();
		return span_now() - 1 - used_now();
	endfunction

	function automatic void close_message();
		wr_cur = 0;
		wr_open = 0;
		wr_drop = 0;
		n_bytes = 0;
		want_len = 0;
	endfunction

	function automatic void queue_result(logic [DW-1:0] d, logic lst, status_t st,
			int unsigned len);
		res_t r;
		int unsigned fr;
		fr = free_now();
		r.data = d;
		r.last = lst;
		r.status = st;
		r.len = LW'(len);
		r.used = AW'(used_now());
		r.free_pl = AW'((fr > HDR_BYTES) ? fr - HDR_BYTES : 0);
		r.can_read = (used_now() != 0);
		pending_results.push_back(r);
	endfunction

	function automatic status_t ring_accept_write(logic [LW-1:0] len, logic [DW-1:0] d,
			logic lst);
		int unsigned need;
		if (!wr_open && !wr_drop) begin
			if (len > max_now() || free_now() < HDR_BYTES + len) begin
				wr_drop = !lst;
				return STAT_NO_ROOM;
			end
			// big-endian header: three zero bytes, then the length
			wr_cur = wr_p % span_now();
			for (int k = 0; k < HDR_BYTES; k++) begin
				ring_mem[wr_cur] = (k == HDR_BYTES - 1) ? DW'(len) : '0;
				wr_cur = (wr_cur + 1) % span_now();
			end
			want_len = len;
			n_bytes = 0;
			wr_open = 1;
		end
		if (wr_drop) begin
			if (lst)
				wr_drop = 0;
			return STAT_NO_ROOM;
		end
		if (n_bytes < want_len) begin
			ring_mem[wr_cur] = d;
			wr_cur = (wr_cur + 1) % span_now();
		end
		if (n_bytes <= want_len)
			n_bytes++;
		if (lst) begin
			need = (want_len != 0) ? want_len : 1;
			if (n_bytes != need) begin
				close_message();
				return STAT_MISMATCH;
			end
			wr_p = wr_cur;
			close_message();
		end
		return STAT_OK;
	endfunction

	function automatic void ring_fetch(func_t f);
		int unsigned p, hdr;
		logic [DW-1:0] body [$];
		if (used_now() == 0) begin
			queue_result('0, 1'b1, STAT_EMPTY, 0);
			return;
		end
		p = rd_p % span_now();
		hdr = 0;
		for (int k = 0; k < HDR_BYTES; k++) begin
			hdr = (hdr << 8) | ring_mem[p];
			p = (p + 1) % span_now();
		end
		if (hdr > max_now()) begin
			queue_result('0, 1'b1, STAT_CORRUPT, 0);
			return;
		end
		for (int k = 0; k < hdr; k++) begin
			body.push_back(ring_mem[p]);
			p = (p + 1) % span_now();
		end
		if (f == FUNC_READ)
			rd_p = p;
		if (hdr == 0) begin
			queue_result('0, 1'b1, STAT_OK, 0);
			return;
		end
		for (int k = 0; k < hdr; k++)
			queue_result(body[k], (k + 1 == hdr), STAT_OK, hdr);
	endfunction

	function automatic void predict_word(func_t f, logic [LW-1:0] len, logic [DW-1:0] d,
			logic lst);
		case (f)
			FUNC_WRITE: queue_result('0, 1'b1, ring_accept_write(len, d, lst), 0);
			FUNC_STATUS: queue_result('0, 1'b1, STAT_OK, 0);
			default: ring_fetch(f);
		endcase
	endfunction

	function automatic void check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			errors++;
			$display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
		end
	endfunction

	always @(posedge clk)
		out_stall <= ($urandom_range(99) < recv_stall_pct);

	always @(posedge clk) begin
		res_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t: result with nothing expected, expected none actual data %0d status %0d",
					$time, data_out, status);
			end else begin
				want = pending_results.pop_front();
				check_field("data_out", want.data, data_out);
				check_field("out_last", want.last, out_last);
				check_field("status", want.status, status);
				check_field("msg_len_out", want.len, msg_len_out);
				check_field("used_bytes", want.used, used_bytes);
				check_field("free_payload", want.free_pl, free_payload);
				check_field("can_read", want.can_read, can_read);
				results_checked++;
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
			$display("Some tests failed");
			$finish;
		end
	end

	// hold the word until accepted; leave valid high so back-to-back words need no toggle
	task automatic push_word(func_t f, logic [LW-1:0] len, logic [DW-1:0] d, logic lst);
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		msg_len <= len;
		data_in <= d;
		data_last <= lst;
		do
			@(posedge clk);
		while (in_stall);
		predict_word(f, len, d, lst);
		words_sent++;
	endtask

	task automatic send_message(logic [LW-1:0] len, int unsigned n_items);
		for (int i = 0; i < n_items; i++)
			push_word(FUNC_WRITE, (i == 0) ? len : LW'($urandom_range(0, 127)),
				DW'($urandom), (i + 1 == n_items));
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(logic idx, logic [SW-1:0] val);
		settle();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		if (idx == REG_RING_SIZE) begin
			cfg_size = val;
			rd_p = 0;
			wr_p = 0;
			close_message();
		end else begin
			cfg_max = val[LW-1:0];
		end
		reg_writes++;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic test_empty_and_status();
		push_word(FUNC_STATUS, '0, '0, 1'b0);
		push_word(FUNC_READ, '1, '1, 1'b1);
		push_word(FUNC_PEEK, '0, '0, 1'b0);
	endtask

	task automatic test_write_read_basics();
		push_word(FUNC_WRITE, 7'd0, 8'hFF, 1'b1);
		push_word(FUNC_WRITE, 7'd2, 8'h00, 1'b0);
		push_word(FUNC_WRITE, 7'h7F, 8'hFF, 1'b1);
		// status query lands inside an open message
		push_word(FUNC_WRITE, 7'd3, 8'h5A, 1'b0);
		push_word(FUNC_STATUS, '0, '0, 1'b0);
		push_word(FUNC_WRITE, 7'd0, 8'hA5, 1'b0);
		push_word(FUNC_WRITE, 7'd64, 8'h3C, 1'b1);
		push_word(FUNC_PEEK, '0, '0, 1'b0);
		push_word(FUNC_READ, '0, '0, 1'b0);
		push_word(FUNC_READ, '0, '0, 1'b0);
		push_word(FUNC_READ, '0, '0, 1'b0);
		push_word(FUNC_READ, '0, '0, 1'b0);
	endtask

	task automatic test_bad_counts();
		send_message(7'd127, 1);
		send_message(7'd65, 2);
		send_message(7'd2, 1);
		send_message(7'd1, 3);
		send_message(7'd0, 2);
		push_word(FUNC_STATUS, '0, '0, 1'b1);
	endtask

	task automatic test_small_ring();
		cfg_write(REG_RING_SIZE, SW'(MIN_SIZE));
		send_message(7'd4, 4);
		send_message(7'd3, 3);
		push_word(FUNC_STATUS, '0, '0, 1'b0);
		send_message(7'd0, 1);
		push_word(FUNC_READ, '0, '0, 1'b0);
		send_message(7'd2, 2);
		push_word(FUNC_PEEK, '0, '0, 1'b0);
		push_word(FUNC_READ, '0, '0, 1'b0);
		// sizes below the floor and above the depth clamp
		cfg_write(REG_RING_SIZE, SW'(3));
		send_message(7'd3, 3);
		send_message(7'd1, 1);
		cfg_write(REG_RING_SIZE, '1);
		cfg_write(REG_MAX_LEN, SW'(0));
		send_message(7'd0, 1);
		send_message(7'd1, 1);
		push_word(FUNC_READ, '0, '0, 1'b0);
		cfg_write(REG_MAX_LEN, SW'(127));
	endtask

	task automatic test_abandon_on_resize();
		send_message(7'd2, 2);
		push_word(FUNC_WRITE, 7'd3, 8'h81, 1'b0);
		cfg_write(REG_RING_SIZE, SW'(64));
		push_word(FUNC_STATUS, '0, '0, 1'b0);
		send_message(7'd2, 2);
		push_word(FUNC_READ, '0, '0, 1'b0);
		push_word(FUNC_READ, '0, '0, 1'b0);
	endtask

	task automatic test_corrupt_length();
		cfg_write(REG_RING_SIZE, SW'(RING_DEPTH));
		cfg_write(REG_MAX_LEN, SW'(MAX_PAYLOAD));
		send_message(7'd5, 5);
		send_message(7'd1, 1);
		cfg_write(REG_MAX_LEN, SW'(4));
		push_word(FUNC_PEEK, '0, '0, 1'b0);
		push_word(FUNC_READ, '0, '0, 1'b0);
		cfg_write(REG_MAX_LEN, SW'(5));
		push_word(FUNC_READ, '0, '0, 1'b0);
		push_word(FUNC_READ, '0, '0, 1'b0);
		push_word(FUNC_READ, '0, '0, 1'b0);
	endtask

	function automatic int unsigned pick_len(int unsigned mx);
		int unsigned r;
		r = $urandom_range(99);
		if (r < 3)
			return mx;
		if (r < 80)
			return $urandom_range(0, (mx < 6) ? mx : 6);
		if (r < 95)
			return $urandom_range(0, mx);
		return $urandom_range(mx + 1, 127);
	endfunction

	task automatic test_random_traffic(int idle_pct, int stall_pct, int unsigned size,
			int unsigned mx, int n_words);
		int start;
		int unsigned r, len;
		cfg_write(REG_RING_SIZE, SW'(size));
		cfg_write(REG_MAX_LEN, SW'(mx));
		sender_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		start = words_sent;
		while (words_sent - start < n_words) begin
			r = $urandom_range(99);
			len = pick_len(mx);
			if (r < 45)
				send_message(LW'(len), (len == 0) ? 1 : len);
			else if (r < 55)
				send_message(LW'(len), $urandom_range(1, len + 3));
			else if (r < 78)
				push_word(FUNC_READ, LW'($urandom), DW'($urandom), 1'($urandom));
			else if (r < 88)
				push_word(FUNC_PEEK, LW'($urandom), DW'($urandom), 1'($urandom));
			else if (r < 94)
				push_word(FUNC_STATUS, LW'($urandom), DW'($urandom), 1'($urandom));
			else
				push_word(FUNC_WRITE, LW'($urandom), DW'($urandom), 1'($urandom));
		end
		settle();
		sender_idle_pct = 0;
		recv_stall_pct = 0;
	endtask

	initial begin
		close_message();
		rd_p = 0;
		wr_p = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_and_status();
		test_write_read_basics();
		test_bad_counts();
		test_small_ring();
		test_abandon_on_resize();
		test_corrupt_length();
		test_random_traffic(0, 0, RING_DEPTH, MAX_PAYLOAD, 48);
		test_random_traffic(87, 0, 48, 16, 48);
		test_random_traffic(0, 87, 24, 6, 48);
		test_random_traffic(27, 27, $urandom_range(MIN_SIZE, 300), $urandom_range(0, 64), 48);

		settle();
		if (pending_results.size() != 0) begin
			errors++;
			$display("%0t: %0d results never arrived", $time, pending_results.size());
		end
		$display("Covered %0d input words, %0d checked results and %0d register writes",
			words_sent, results_checked, reg_writes);
		$display("across directed cases and four traffic phases with varied ring sizes.");
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

>>> length_prefixed_message_ring_core.f
src/lpmr_pkg.sv
src/lpmr_ram.sv
src/lpmr_ctrl.sv
src/length_prefixed_message_ring_core.sv
sim/tb_length_prefixed_message_ring_core.sv
